// ===== rtl/ps2mg_pkg.sv =====
// shared types and constants for the ps/2 mouse packet decoder and stroke detector
// no dependencies
package ps2mg_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELTA_W  = 9;
  localparam int unsigned TRAVEL_W = 16;
  localparam int unsigned TOL_W    = 8;
  localparam int unsigned CFG_W    = 16;

  // configuration register indexes
  localparam logic CFG_GESTURE_LENGTH = 1'b0;
  localparam logic CFG_MOVE_TOLERANCE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DRAW = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } pos_e;

  typedef struct packed {
    phase_e                      phase;
    logic signed [TRAVEL_W-1:0] travel;
  } det_state_t;

endpackage

// ===== rtl/ps2mg_detector.sv =====
// stroke detector next-state logic, one packet per evaluation
// depends on ps2mg_pkg
module ps2mg_detector import ps2mg_pkg::*; (
  input  logic                      en_i,
  input  logic [BYTE_W-1:0]         status_i,
  input  logic signed [DELTA_W-1:0] dx_i,
  input  logic signed [DELTA_W-1:0] dy_i,
  input  logic signed [TRAVEL_W-1:0] length_i,
  input  logic [TOL_W-1:0]          tol_i,
  input  det_state_t                cur_i,
  output det_state_t                nxt_o
);

  logic                      xs, ys, len_pos, len_neg, x_match, y_match;
  logic signed [DELTA_W:0]   dx_ext, dy_ext;
  logic [DELTA_W:0]          dx_mag, dy_mag, tol_ext;
  logic signed [TRAVEL_W:0]  sum;
  logic signed [TRAVEL_W-1:0] sat_sum;
  det_state_t                mid;
  det_state_t                upd;

  assign xs      = status_i[4];
  assign ys      = status_i[5];
  assign len_neg = length_i[TRAVEL_W-1];
  assign len_pos = !length_i[TRAVEL_W-1] && (length_i != '0);
  assign x_match = (xs && len_neg) || (!xs && len_pos);
  assign y_match = (ys && len_neg) || (!ys && len_pos);

  assign dx_ext  = {dx_i[DELTA_W-1], dx_i};
  assign dy_ext  = {dy_i[DELTA_W-1], dy_i};
  assign dx_mag  = dx_ext[DELTA_W] ? $unsigned(-dx_ext) : $unsigned(dx_ext);
  assign dy_mag  = dy_ext[DELTA_W] ? $unsigned(-dy_ext) : $unsigned(dy_ext);
  assign tol_ext = {{(DELTA_W+1-TOL_W){1'b0}}, tol_i};

  // right button moves idle into draw, release clears the sum and returns draw to idle
  always_comb begin
    mid = cur_i;
    if (status_i[1]) begin
      if (cur_i.phase == PH_IDLE) mid.phase = PH_DRAW;
    end else begin
      mid.travel = '0;
      if (cur_i.phase == PH_DRAW) mid.phase = PH_IDLE;
    end
  end

  // saturating add of dy onto the running sum
  assign sum = {mid.travel[TRAVEL_W-1], mid.travel}
             + {{(TRAVEL_W+1-DELTA_W){dy_i[DELTA_W-1]}}, dy_i};
  always_comb begin
    if (sum[TRAVEL_W] != sum[TRAVEL_W-1]) begin
      sat_sum = sum[TRAVEL_W] ? {1'b1, {(TRAVEL_W-1){1'b0}}} : {1'b0, {(TRAVEL_W-1){1'b1}}};
    end else begin
      sat_sum = sum[TRAVEL_W-1:0];
    end
  end

  always_comb begin
    upd = mid;
    if (mid.phase == PH_DRAW) begin
      if (x_match) begin
        if (y_match) begin
          upd.travel = sat_sum;
        end else if (dy_mag > tol_ext) begin
          upd.travel = '0;
        end
        // goal test on the updated sum
        if (len_pos) begin
          if (upd.travel > length_i) upd.phase = PH_DONE;
        end else if (length_i > upd.travel) begin
          upd.phase = PH_DONE;
        end
      end else if (dx_mag > tol_ext) begin
        upd.travel = '0;
      end
    end
  end

  assign nxt_o = en_i ? upd : cur_i;

endmodule

// ===== rtl/ps2_mouse_packet_gesture.sv =====
// ps/2 mouse 3-byte packet decoder with right-button stroke detector
// a third byte passes through the input register, then its result is loaded into the output register
// throughput: one byte per cycle, sustained, while the output side takes results
// a third byte waits in the input register while an untaken result holds the output register
// reset (asynchronous, active low) clears alignment, detector phase, sum and config registers
module ps2_mouse_packet_gesture import ps2mg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  // byte input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [BYTE_W-1:0]          rx_byte_i,
  // packet result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       left_button_o,
  output logic                       right_button_o,
  output logic                       middle_button_o,
  output logic signed [DELTA_W-1:0]  delta_x_o,
  output logic signed [DELTA_W-1:0]  delta_y_o,
  output logic                       x_overflow_o,
  output logic                       y_overflow_o,
  output logic [1:0]                 gesture_phase_out_o,
  output logic signed [TRAVEL_W-1:0] travel_sum_o
);

  // configuration registers
  logic signed [TRAVEL_W-1:0] gesture_length_q;
  logic [TOL_W-1:0]           move_tolerance_q;

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;

  // packet alignment state
  pos_e              pos_q, pos_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [BYTE_W-1:0] second_q, second_d;

  // detector state
  det_state_t det_q, det_d;

  // output register
  logic                       out_valid_q;
  logic [BYTE_W-1:0]          res_status_q;
  logic signed [DELTA_W-1:0]  res_dx_q, res_dy_q;
  det_state_t                 res_det_q;

  logic                       in_xfer, out_free, produce, advance, det_en;
  logic signed [DELTA_W-1:0]  dx, dy;

  // ---------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gesture_length_q <= '0;
      move_tolerance_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GESTURE_LENGTH: gesture_length_q <= cfg_wdata_i[TRAVEL_W-1:0];
        CFG_MOVE_TOLERANCE: move_tolerance_q <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // handshake: the byte in the input register moves on unless it
  // completes a packet and the output register is still occupied
  // ---------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign produce    = (pos_q == POS_THIRD);
  assign advance    = in_valid_q && (!produce || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------
  // packet alignment: a first byte needs its sync bit, else dropped
  // ---------------------------------------------------------------
  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    case (pos_q)
      POS_SECOND: begin
        second_d = in_byte_q;
        pos_d    = POS_THIRD;
      end
      POS_THIRD: begin
        pos_d = POS_FIRST;
      end
      default: begin
        if (in_byte_q[3]) begin
          first_d = in_byte_q;
          pos_d   = POS_SECOND;
        end else begin
          pos_d = POS_FIRST;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_FIRST;
      first_q  <= '0;
      second_q <= '0;
    end else if (advance) begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // ---------------------------------------------------------------
  // movement decode, sign bits from the status byte
  // ---------------------------------------------------------------
  assign dx = {first_q[4], second_q};
  assign dy = {first_q[5], in_byte_q};

  // overflow packets leave the detector alone
  assign det_en = produce && (first_q[7:6] == 2'b00);

  ps2mg_detector u_detector (
    .en_i     (det_en),
    .status_i (first_q),
    .dx_i     (dx),
    .dy_i     (dy),
    .length_i (gesture_length_q),
    .tol_i    (move_tolerance_q),
    .cur_i    (det_q),
    .nxt_o    (det_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q.phase  <= PH_IDLE;
      det_q.travel <= '0;
    end else if (advance) begin
      det_q <= det_d;
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      res_status_q <= first_q;
      res_dx_q     <= dx;
      res_dy_q     <= dy;
      res_det_q    <= det_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_button_o       = res_status_q[0];
  assign right_button_o      = res_status_q[1];
  assign middle_button_o     = res_status_q[2];
  assign delta_x_o           = res_dx_q;
  assign delta_y_o           = res_dy_q;
  assign x_overflow_o        = res_status_q[6];
  assign y_overflow_o        = res_status_q[7];
  assign gesture_phase_out_o = res_det_q.phase;
  assign travel_sum_o        = res_det_q.travel;

`ifndef SYNTHESIS
  // done is sticky
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_q.phase == PH_DONE |=> det_q.phase == PH_DONE)
    else $error("detector left done");

  // a completed packet realigns to the first byte
  a_realign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && produce |=> pos_q == POS_FIRST && out_valid_q)
    else $error("packet completion did not realign or load result");

  // an unsynced first byte is dropped
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pos_q == POS_FIRST && !in_byte_q[3] |=> pos_q == POS_FIRST)
    else $error("unsynced byte taken as packet start");

  // overflow packets leave the detector unchanged
  a_ovf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && produce && first_q[7:6] != 2'b00 |=> $stable(det_q))
    else $error("overflow packet changed detector state");
`endif

endmodule
